// ===== design/lost_pkg.sv =====
// Package for the LRU open-slot table: sizes, state and status codes,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package lost_pkg;

    localparam int SLOTS       = 8;
    localparam int FIRST_ALLOC = 2;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int KEY_W       = 32;
    localparam int STAMP_W     = 32;
    localparam int SLOT_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int S_DATA_W    = 32;  // rel_key
    localparam int M_DATA_W    = 40;  // slot, victim_key, zero fill

    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(FIRST_ALLOC);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT      = 2'd0,
        STAT_FILL     = 2'd1,
        STAT_EVICT    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic start;   // capture request, restart scan
        logic rd;      // read slot at scan index, advance index
        logic commit;  // apply update, load result register
    } dp_cmd_t;

    typedef struct packed {
        logic rd_last;   // scan index at final slot
        logic out_free;  // result register can take a new transaction
    } dp_sts_t;

    // Low bits of a slot index as carried in the result
    function automatic logic [SLOT_W-1:0] slot_field(input idx_t idx);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/lost_ctrl.sv =====
// Controller FSM for the LRU open-slot table: sequences accept, slot scan,
// pipeline drain and commit. Depends on lost_pkg.
`default_nettype none

module lost_ctrl
    import lost_pkg::*;
(
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      s_tvalid,
    output logic     s_tready,
    input  dp_sts_t  sts,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_SCAN;
            end
            S_SCAN: begin
                if (sts.rd_last) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.rd     = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            S_SCAN: begin
                cmd.rd = 1'b1;
            end
            S_COMMIT: begin
                cmd.commit = sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/lost_dp.sv =====
// Datapath for the LRU open-slot table: key and stamp memories, valid bits,
// stamp counter, scan evaluation and result register. Depends on lost_pkg.
`default_nettype none

module lost_dp
    import lost_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire  [KEY_W-1:0]        rel_key,
    input  wire                     rel_exists,
    input  dp_cmd_t                 cmd,
    output dp_sts_t                 sts,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [M_DATA_W-1:0]     m_tdata,
    output logic [STATUS_W-1:0]     m_tuser
);

    // storage
    logic [KEY_W-1:0]   key_mem   [SLOTS];
    logic [STAMP_W-1:0] stamp_mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [STAMP_W-1:0] counter_reg, counter_next;

    // request
    logic [KEY_W-1:0]   key_reg;
    logic               exists_reg;

    // scan pipeline
    idx_t               rd_idx_reg;
    idx_t               eval_idx_reg;
    logic               eval_vld_reg;
    logic [KEY_W-1:0]   key_rd_reg;
    logic [STAMP_W-1:0] stamp_rd_reg;

    // scan results
    logic               hit_found_reg, hit_found_next;
    idx_t               hit_idx_reg, hit_idx_next;
    logic               free_found_reg, free_found_next;
    idx_t               free_idx_reg, free_idx_next;
    logic [STAMP_W-1:0] least_reg, least_next;
    idx_t               least_idx_reg, least_idx_next;
    logic [KEY_W-1:0]   victim_reg, victim_next;

    // commit
    status_t            cm_status;
    idx_t               cm_idx;
    logic [KEY_W-1:0]   cm_victim;
    logic               wr_en;
    logic               set_valid;

    // result register
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    assign sts.rd_last  = (rd_idx_reg == LAST_IDX);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    // memories: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) key_mem[cm_idx] <= key_reg;
        if (cmd.rd) key_rd_reg <= key_mem[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) stamp_mem[cm_idx] <= counter_next;
        if (cmd.rd) stamp_rd_reg <= stamp_mem[rd_idx_reg];
    end

    // scan index and eval pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_vld_reg <= 1'b0;
        end else begin
            eval_vld_reg <= cmd.rd;
        end
        if (cmd.start) begin
            rd_idx_reg <= '0;
        end else if (cmd.rd) begin
            rd_idx_reg <= rd_idx_reg + idx_t'(1);
        end
        eval_idx_reg <= rd_idx_reg;
        if (cmd.start) begin
            key_reg    <= rel_key;
            exists_reg <= rel_exists;
        end
    end

    // per-slot evaluation: first hit; first free and least stamp from FIRST_IDX up (ties to lowest)
    always_comb begin
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        least_next      = least_reg;
        least_idx_next  = least_idx_reg;
        victim_next     = victim_reg;
        if (cmd.start) begin
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end else if (eval_vld_reg) begin
            if (!hit_found_reg && valid_reg[eval_idx_reg] && (key_rd_reg == key_reg)) begin
                hit_found_next = 1'b1;
                hit_idx_next   = eval_idx_reg;
            end
            if (eval_idx_reg >= FIRST_IDX) begin
                if (!free_found_reg && !valid_reg[eval_idx_reg]) begin
                    free_found_next = 1'b1;
                    free_idx_next   = eval_idx_reg;
                end
                if ((eval_idx_reg == FIRST_IDX) || (stamp_rd_reg < least_reg)) begin
                    least_next     = stamp_rd_reg;
                    least_idx_next = eval_idx_reg;
                    victim_next    = key_rd_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
        end
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        least_reg     <= least_next;
        least_idx_reg <= least_idx_next;
        victim_reg    <= victim_next;
    end

    // decision at commit
    always_comb begin
        cm_victim = '0;
        set_valid = 1'b0;
        if (hit_found_reg) begin
            cm_status = STAT_HIT;
            cm_idx    = hit_idx_reg;
        end else if (!exists_reg) begin
            cm_status = STAT_NOTFOUND;
            cm_idx    = '0;
        end else if (free_found_reg) begin
            cm_status = STAT_FILL;
            cm_idx    = free_idx_reg;
            set_valid = cmd.commit;
        end else begin
            cm_status = STAT_EVICT;
            cm_idx    = least_idx_reg;
            cm_victim = victim_reg;
            set_valid = cmd.commit;
        end
        wr_en = cmd.commit && (cm_status != STAT_NOTFOUND);
    end

    always_comb begin
        valid_next   = valid_reg;
        counter_next = counter_reg + STAMP_W'(1);
        if (set_valid) valid_next[cm_idx] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            counter_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            if (wr_en) counter_reg <= counter_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.commit) begin
            m_tdata_reg <= M_DATA_W'({cm_victim, slot_field(cm_idx)});
            m_tuser_reg <= cm_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== design/lru_open_slot_table.sv =====
// Top level of the LRU open-slot table: joins controller and datapath.
// Depends on lost_pkg, lost_ctrl and lost_dp.
//
// Usage
//   Slave channel (s_): one open request per transaction. s_tdata carries
//   rel_key, s_tuser carries rel_exists.
//   Master channel (m_): one result per request. m_tuser carries status
//   (hit, filled free slot, evicted and filled, not found); m_tdata carries
//   slot index (low 3 bits) and victim_key.
//   Sequence: after the accepting edge the controller scans every slot of the
//   key/stamp memories through their single registered read port, then
//   passes through a drain state and a commit state before m_tvalid rises.
//   Requests are handled one at a time; s_tready is high only between
//   requests, so a new request is taken only after the last one commits.
//   Reset: valid bits and the stamp counter clear; key and stamp memories
//   are not cleared, as only valid entries are ever consulted.
//   Stall: a result waits in the output register while m_tready is low; a
//   new request is still accepted and scanned, and its commit waits until
//   the output register frees.
`default_nettype none

module lru_open_slot_table
    import lost_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [S_DATA_W-1:0]     s_tdata,   // [31:0] rel_key
    input  wire                     s_tuser,   // [0] rel_exists
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [M_DATA_W-1:0]     m_tdata,   // [2:0] slot, [34:3] victim_key, zero fill
    output logic [STATUS_W-1:0]     m_tuser    // [1:0] status
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    lost_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lost_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rel_key    (s_tdata),
        .rel_exists (s_tuser),
        .cmd        (cmd),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // one request in flight: no accept straight after an accept
    a_single_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in flight");

    // commit only when the result register can take it
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("commit while result register occupied");

    // not found carries zero slot and victim
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_NOTFOUND)) |-> (m_tdata == '0))
        else $error("not-found result with non-zero payload");

    // only an eviction reports a victim key
    a_victim_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tuser == STAT_HIT) || (m_tuser == STAT_FILL)))
            |-> (m_tdata[M_DATA_W-1:SLOT_W] == '0))
        else $error("victim key reported without eviction");

endmodule

`default_nettype wire
